/* design/steg_pkg.sv */
// ----------------------------------------------------------------------------
// steg_pkg
// shared widths, register codes, request structs and the sine table builder
// ----------------------------------------------------------------------------
package steg_pkg;

  // default table size, log2 of the full-wave entry count
  localparam int unsigned TABLE_BITS_DEF = 10;

  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned AMP_W      = 16;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ENV_W      = 17;
  localparam int unsigned MCAND_W    = MAG_W + AMP_W;
  localparam int unsigned PROD_W     = MCAND_W + ENV_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [ENV_W-1:0] ENV_ONE    = ENV_W'(1) << 16;
  localparam logic [MAG_W-1:0] SAMPLE_MAX = '1;
  localparam logic [AMP_W-1:0] AMP_RESET  = AMP_W'(1) << 15;
  localparam logic [LEN_W-1:0] LEN_RESET  = LEN_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP     = 3'd0,
    REG_TONE_LENGTH    = 3'd1,
    REG_ATTACK_LENGTH  = 3'd2,
    REG_RELEASE_LENGTH = 3'd3,
    REG_AMPLITUDE      = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] num;
    logic [LEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [MCAND_W-1:0] mcand;
    logic [ENV_W-1:0]   mplier;
  } mul_req_t;

  // taylor series constants, only evaluated while building the rom
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] TAYLOR_DIV [10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  // round(32767*sin(pi/2 * j/2^qbits)), truncating q2.30 series
  function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] j,
                                                    input int unsigned qbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] acc;
    x    = (j * HALF_PI_Q30) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    acc  = signed'(x);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[4'(n-1)];
      if (n[0]) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (unsigned'(acc) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

/* design/steg_if.sv */
// ----------------------------------------------------------------------------
// steg channel interfaces
// request, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface steg_in_if import steg_pkg::*; ();
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink   (input valid, input start_req, output ready);
endinterface

interface steg_out_if import steg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       active;

  modport source (output valid, output sample, output last, output active, input ready);
  modport sink   (input valid, input sample, input last, input active, output ready);
endinterface

interface steg_cfg_if import steg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/steg_sine_rom.sv */
// ----------------------------------------------------------------------------
// steg_sine_rom
// quarter-wave sine rom with registered read, returns magnitude and sign
// ----------------------------------------------------------------------------
module steg_sine_rom import steg_pkg::*; #(
  parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  logic [TABLE_BITS-1:0] addr_i,
  output logic [MAG_W-1:0]      mag_o,
  output logic                  neg_o
);

  localparam int unsigned QBITS   = TABLE_BITS - 2;
  localparam int unsigned QUARTER = 1 << QBITS;
  localparam int unsigned IDX_W   = QBITS + 1;

  typedef logic [MAG_W-1:0] rom_t [QUARTER+1];

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k <= QUARTER; k++) begin
      t[IDX_W'(k)] = quarter_sine(64'(k), QBITS);
    end
    return t;
  endfunction

  localparam rom_t ROM_TABLE = build_rom();

  logic [QBITS-1:0] frac;
  logic [IDX_W-1:0] rd_idx;
  logic [MAG_W-1:0] mag_q;
  logic             neg_q;

  // odd quarters run the table backwards
  assign frac   = addr_i[QBITS-1:0];
  assign rd_idx = addr_i[QBITS] ? IDX_W'(QUARTER) - {1'b0, frac} : {1'b0, frac};

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mag_q <= ROM_TABLE[rd_idx];
      neg_q <= addr_i[TABLE_BITS-1];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

/* design/steg_env_div.sv */
// ----------------------------------------------------------------------------
// steg_env_div
// bit-serial restoring divider for the envelope, num*2^16/den with num < den
// ----------------------------------------------------------------------------
module steg_env_div import steg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             busy_o,
  output logic [LEN_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(LEN_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0] quo_q, quo_d;
  logic [LEN_W-1:0] den_q, den_d;
  logic [LEN_W:0]   trial;
  logic             take;

  assign trial = {rem_q, 1'b0};
  assign take  = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    if (req_i.start) begin
      cnt_d = CNT_W'(LEN_W);
      rem_d = req_i.num;
      den_d = req_i.den;
      quo_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      rem_d = take ? LEN_W'(trial - {1'b0, den_q}) : trial[LEN_W-1:0];
      quo_d = {quo_q[LEN_W-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

endmodule

/* design/steg_serial_mult.sv */
// ----------------------------------------------------------------------------
// steg_serial_mult
// shift-add multiplier, one multiplier bit per cycle, full product kept
// ----------------------------------------------------------------------------
module steg_serial_mult import steg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mul_req_t          req_i,
  output logic              busy_o,
  output logic [PROD_W-1:0] prod_o
);

  localparam int unsigned CNT_W = $clog2(ENV_W + 1);

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [MCAND_W-1:0] mcand_q, mcand_d;
  logic [MCAND_W-1:0] acc_q, acc_d;
  logic [ENV_W-1:0]   mq_q, mq_d;
  logic [MCAND_W:0]   sum;

  assign sum = {1'b0, acc_q} + (mq_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    mq_d    = mq_q;
    if (req_i.start) begin
      cnt_d   = CNT_W'(ENV_W);
      mcand_d = req_i.mcand;
      acc_d   = '0;
      mq_d    = req_i.mplier;
    end else if (cnt_q != '0) begin
      // low product bits shift into the multiplier register
      cnt_d = cnt_q - CNT_W'(1);
      acc_d = sum[MCAND_W:1];
      mq_d  = {sum[0], mq_q[ENV_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    mq_q    <= mq_d;
  end

  assign busy_o = cnt_q != '0;
  assign prod_o = {acc_q, mq_q};

endmodule

/* design/sine_tone_ar_envelope_generator_core.sv */
// ----------------------------------------------------------------------------
// sine_tone_ar_envelope_generator_core
// sine tone with linear attack/release envelope, one sample per request
// ----------------------------------------------------------------------------
// flow: a tone sample passes S_ROM, S_MUL1, S_MUL2 and S_DONE before it is
//   offered; a silent one (index at or past the tone length) goes to S_DONE
// a tone request holds the core for the two 17-step passes of the shared
//   bit-serial multiplier; no new request is taken until the result is loaded
// reset: registers return to their defaults and the tone is idle (index equals
//   tone length, phase zero); output channel empty
module sine_tone_ar_envelope_generator_core import steg_pkg::*; #(
  parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  steg_cfg_if.sink   cfg_i,
  steg_in_if.sink    in_i,
  steg_out_if.source out_o
);

  // product bits below the q1.15 * q1.16 binary point
  localparam int unsigned PROD_SHIFT = MAG_W + LEN_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROM  = 5'b00010,
    S_MUL1 = 5'b00100,
    S_MUL2 = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [STEP_W-1:0] step_q;
  logic [LEN_W-1:0]  tone_len_q;
  logic [LEN_W-1:0]  attack_len_q;
  logic [LEN_W-1:0]  release_len_q;
  logic [AMP_W-1:0]  amp_q;

  // tone state
  logic [LEN_W-1:0]   idx_q, idx_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               env_full_q, env_full_d;

  // result waiting for the output register
  logic [SAMPLE_W-1:0] res_sample_q, res_sample_d;
  logic                res_last_q, res_last_d;
  logic                res_active_q, res_active_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic                out_last_q;
  logic                out_active_q;
  logic                out_load;

  // request decode
  logic               accept;
  logic [LEN_W-1:0]   idx_eff;
  logic [PHASE_W-1:0] phase_eff;
  logic               tone_on;
  logic [LEN_W-1:0]   a_eff;
  logic [LEN_W-1:0]   r_eff;
  logic               in_attack;
  logic               in_release;

  // datapath units
  div_req_t          div_req;
  logic              div_busy;
  logic [LEN_W-1:0]  div_quo;
  mul_req_t          mul_req;
  logic              mul_busy;
  logic [PROD_W-1:0] mul_prod;
  logic [MAG_W-1:0]  rom_mag;
  logic              rom_neg;
  logic [ENV_W-1:0]  env;
  logic [ENV_W-1:0]  mag_full;
  logic [MAG_W-1:0]  mag_sat;
  logic [SAMPLE_W-1:0] mag_ext;

  // ---------------------------------------------------------------------------
  // register writes, always accepted; unknown indexes fall through
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= '0;
      tone_len_q    <= LEN_RESET;
      attack_len_q  <= LEN_RESET;
      release_len_q <= LEN_RESET;
      amp_q         <= AMP_RESET;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_PHASE_STEP:     step_q        <= cfg_i.data[STEP_W-1:0];
        REG_TONE_LENGTH:    tone_len_q    <= cfg_i.data[LEN_W-1:0];
        REG_ATTACK_LENGTH:  attack_len_q  <= cfg_i.data[LEN_W-1:0];
        REG_RELEASE_LENGTH: release_len_q <= cfg_i.data[LEN_W-1:0];
        REG_AMPLITUDE:      amp_q         <= cfg_i.data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // request decode: restart, idle check and envelope segment
  // ---------------------------------------------------------------------------
  assign in_i.ready = state_q == S_IDLE;
  assign accept     = in_i.valid && in_i.ready;

  assign idx_eff   = in_i.start_req ? '0 : idx_q;
  assign phase_eff = in_i.start_req ? '0 : phase_q;
  assign tone_on   = idx_eff < tone_len_q;

  // zero lengths behave as one
  assign a_eff = (attack_len_q == '0) ? LEN_W'(1) : attack_len_q;
  assign r_eff = (release_len_q == '0) ? LEN_W'(1) : release_len_q;

  // attack wins over release; release when i > N - R, done without signs
  assign in_attack  = idx_eff < a_eff;
  assign in_release = ({1'b0, idx_eff} + {1'b0, r_eff}) > {1'b0, tone_len_q};

  always_comb begin
    div_req.start = accept && tone_on && (in_attack || in_release);
    div_req.num   = in_attack ? idx_eff : tone_len_q - idx_eff;
    div_req.den   = in_attack ? a_eff : r_eff;
  end

  steg_env_div u_env_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // rom is read at the request edge with the phase before it advances
  steg_sine_rom #(
    .TABLE_BITS (TABLE_BITS)
  ) u_sine_rom (
    .clk_i   (clk_i),
    .rd_en_i (accept && tone_on),
    .addr_i  (phase_eff[PHASE_W-1 -: TABLE_BITS]),
    .mag_o   (rom_mag),
    .neg_o   (rom_neg)
  );

  // ---------------------------------------------------------------------------
  // shared multiplier: first |rom| * amplitude, then that product * envelope
  // ---------------------------------------------------------------------------
  assign env = env_full_q ? ENV_ONE : {1'b0, div_quo};

  always_comb begin
    mul_req.start  = 1'b0;
    mul_req.mcand  = MCAND_W'(rom_mag);
    mul_req.mplier = ENV_W'(amp_q);
    if (state_q == S_ROM) begin
      mul_req.start = 1'b1;
    end else if (state_q == S_MUL1 && !mul_busy) begin
      mul_req.start  = 1'b1;
      mul_req.mcand  = mul_prod[MCAND_W-1:0];
      mul_req.mplier = env;
    end
  end

  steg_serial_mult u_serial_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .busy_o (mul_busy),
    .prod_o (mul_prod)
  );

  // truncate, saturate to 32767, then restore the sign
  assign mag_full = mul_prod[PROD_W-1:PROD_SHIFT];
  assign mag_sat  = (mag_full > ENV_W'(SAMPLE_MAX)) ? SAMPLE_MAX : mag_full[MAG_W-1:0];
  assign mag_ext  = {1'b0, mag_sat};

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    phase_d      = phase_q;
    env_full_d   = env_full_q;
    res_sample_d = res_sample_q;
    res_last_d   = res_last_q;
    res_active_d = res_active_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (tone_on) begin
            idx_d        = idx_eff + LEN_W'(1);
            phase_d      = phase_eff + {1'b0, step_q};
            env_full_d   = !(in_attack || in_release);
            res_last_d   = (idx_eff + LEN_W'(1)) == tone_len_q;
            res_active_d = 1'b1;
            state_d      = S_ROM;
          end else begin
            // silent request: hold index and phase (restart still clears them)
            idx_d        = idx_eff;
            phase_d      = phase_eff;
            res_sample_d = '0;
            res_last_d   = 1'b0;
            res_active_d = 1'b0;
            state_d      = S_DONE;
          end
        end
      end
      S_ROM: begin
        state_d = S_MUL1;
      end
      S_MUL1: begin
        if (!mul_busy) begin
          state_d = S_MUL2;
        end
      end
      S_MUL2: begin
        if (!mul_busy) begin
          res_sample_d = rom_neg ? (~mag_ext + SAMPLE_W'(1)) : mag_ext;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= LEN_RESET;
      phase_q     <= '0;
      env_full_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      env_full_q  <= env_full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_sample_q <= res_sample_d;
    res_last_q   <= res_last_d;
    res_active_q <= res_active_d;
    if (out_load) begin
      out_sample_q <= res_sample_q;
      out_last_q   <= res_last_q;
      out_active_q <= res_active_q;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.sample = signed'(out_sample_q);
  assign out_o.last   = out_last_q;
  assign out_o.active = out_active_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // envelope quotient must be settled before the second multiply pass starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL1 && !mul_busy) |-> !div_busy)
    else $error("envelope divider still busy at second multiply");

  // multiplier only runs inside the two multiply states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_busy |-> (state_q == S_MUL1 || state_q == S_MUL2))
    else $error("multiplier busy outside multiply states");

  // a silent result carries neither sample nor last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_active_q) |-> (out_sample_q == '0 && !out_last_q))
    else $error("inactive result with nonzero payload");

  // a finished result waits while the output register is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_o.ready) |=> state_q == S_DONE)
    else $error("result dropped under output stall");

endmodule
